[sv/nrmc_pkg.sv]
`default_nettype none

package nrmc_pkg;

   localparam int unsigned MAX_SENTENCE = 80;
   localparam int unsigned LEN_W        = 7;
   localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_SENTENCE);

   localparam int unsigned POS_CHARS = 11;
   localparam int unsigned MOT_CHARS = 5;
   localparam int unsigned POS_W     = 4 * POS_CHARS;
   localparam int unsigned MOT_W     = 4 * MOT_CHARS;
   localparam int unsigned NUM_W     = 20;
   localparam logic [NUM_W-1:0] NUM_MAX = NUM_W'(999999);

   localparam logic [1:0] KIND_NONE = 2'd0;
   localparam logic [1:0] KIND_RMC  = 2'd1;
   localparam logic [1:0] KIND_GGA  = 2'd2;
   localparam logic [1:0] KIND_GSA  = 2'd3;

   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_A_UP   = 8'h41;
   localparam logic [7:0] CH_F_UP   = 8'h46;
   localparam logic [7:0] CH_A_LOW  = 8'h61;
   localparam logic [7:0] CH_F_LOW  = 8'h66;
   localparam logic [7:0] CH_N_UP   = 8'h4E;
   localparam logic [7:0] CH_E_UP   = 8'h45;

   localparam logic [3:0] CODE_DOT   = 4'd10;
   localparam logic [3:0] CODE_OTHER = 4'd14;

   localparam logic [4:0] FLD_TYPE   = 5'd0;
   localparam logic [4:0] FLD_TIME   = 5'd1;
   localparam logic [4:0] FLD_STATUS = 5'd2;
   localparam logic [4:0] FLD_LAT    = 5'd3;
   localparam logic [4:0] FLD_NS     = 5'd4;
   localparam logic [4:0] FLD_LON    = 5'd5;
   localparam logic [4:0] FLD_EW     = 5'd6;
   localparam logic [4:0] FLD_SPEED  = 5'd7;
   localparam logic [4:0] FLD_COURSE = 5'd8;
   localparam logic [4:0] FLD_DATE   = 5'd9;

   typedef struct packed {
      logic             start;
      logic             chr;
      logic             fend;
      logic             finish;
      logic             ok;
      logic [1:0]       kind;
      logic [4:0]       index;
      logic [LEN_W-1:0] count;
      logic [7:0]       data;
   } nrmc_evt_type;

   typedef struct packed {
      logic [1:0]       sentence_kind;
      logic             checksum_ok;
      logic [NUM_W-1:0] utc_time;
      logic             fix_valid;
      logic             is_north;
      logic             is_east;
      logic [POS_W-1:0] latitude_text;
      logic [POS_W-1:0] longitude_text;
      logic [MOT_W-1:0] speed_text;
      logic [MOT_W-1:0] course_text;
      logic [NUM_W-1:0] date_value;
      logic [15:0]      frame_count;
   } nrmc_rsp_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   function automatic logic [3:0] char_code(input logic [7:0] c);
      logic [3:0] r;
      if (is_digit(c)) begin
         r = c[3:0];
      end else if (c == CH_DOT) begin
         r = CODE_DOT;
      end else begin
         r = CODE_OTHER;
      end
      return r;
   endfunction

   // bit 4 flags a byte that is no hex digit
   function automatic logic [4:0] hex_decode(input logic [7:0] c);
      logic [4:0] r;
      if (is_digit(c)) begin
         r = {1'b0, c[3:0]};
      end else if ((c >= CH_A_UP && c <= CH_F_UP) || (c >= CH_A_LOW && c <= CH_F_LOW)) begin
         r = {1'b0, c[3:0] + 4'd9};
      end else begin
         r = 5'b10000;
      end
      return r;
   endfunction

   // sel 0 RMC, 1 GGA, 2 GSA; pos counts from the first byte after the dollar
   function automatic logic [7:0] kind_char(input logic [1:0] sel, input logic [2:0] pos);
      logic [7:0] r;
      case (pos)
         3'd0: r = 8'h47;
         3'd1: r = 8'h50;
         3'd2: r = (sel == 2'd0) ? 8'h52 : 8'h47;
         3'd3: r = (sel == 2'd0) ? 8'h4D : ((sel == 2'd1) ? 8'h47 : 8'h53);
         3'd4: r = (sel == 2'd0) ? 8'h43 : 8'h41;
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   function automatic logic [POS_W-1:0] put_pos(input logic [POS_W-1:0] w,
                                                input logic [LEN_W-1:0] k,
                                                input logic [7:0] c);
      logic [POS_W-1:0] r;
      r = w;
      for (int j = 0; j < POS_CHARS; j++) begin
         if (k == LEN_W'(POS_CHARS - 1 - j)) r[4*j +: 4] = char_code(c);
      end
      return r;
   endfunction

   function automatic logic [MOT_W-1:0] put_mot(input logic [MOT_W-1:0] w,
                                                input logic [LEN_W-1:0] k,
                                                input logic [7:0] c);
      logic [MOT_W-1:0] r;
      r = w;
      for (int j = 0; j < MOT_CHARS; j++) begin
         if (k == LEN_W'(MOT_CHARS - 1 - j)) r[4*j +: 4] = char_code(c);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

[sv/nrmc_framer.sv]
`default_nettype none

module nrmc_framer (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  step,
   input  wire logic [7:0]            rx_byte,
   output logic                       result_due,
   output nrmc_pkg::nrmc_evt_type     evt
);
   import nrmc_pkg::*;

   typedef enum logic [1:0] {PH_WAIT, PH_BODY, PH_HEX_HI, PH_HEX_LO} phase_type;

   phase_type        phase_ff, phase_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [7:0]       xor_ff, xor_in;
   logic [3:0]       hi_ff, hi_in;
   logic             bad_ff, bad_in;
   logic [4:0]       idx_ff, idx_in;
   logic [LEN_W-1:0] cnt_ff, cnt_in;
   logic [1:0]       pend_ff, pend_in;
   logic [2:0]       match_ff, match_in;

   logic [4:0] hex;
   logic       do_end;
   logic       do_char;

   assign hex        = hex_decode(rx_byte);
   assign result_due = (phase_ff == PH_HEX_LO) && (len_ff < MAX_LEN);

   always_comb begin
      phase_in   = phase_ff;
      len_in     = len_ff;
      xor_in     = xor_ff;
      hi_in      = hi_ff;
      bad_in     = bad_ff;
      idx_in     = idx_ff;
      cnt_in     = cnt_ff;
      pend_in    = pend_ff;
      match_in   = match_ff;
      do_end     = 1'b0;
      do_char    = 1'b0;
      evt        = '0;
      evt.kind   = pend_ff;
      evt.index  = idx_ff;
      evt.count  = cnt_ff;
      evt.data   = rx_byte;
      evt.ok     = !hex[4] && !bad_ff && ({hi_ff, hex[3:0]} == xor_ff) && (pend_ff != KIND_NONE);

      if (step) begin
         if (phase_ff == PH_WAIT) begin
            if (rx_byte == CH_DOLLAR) begin
               phase_in  = PH_BODY;
               len_in    = LEN_W'(1);
               xor_in    = '0;
               hi_in     = '0;
               bad_in    = 1'b0;
               idx_in    = '0;
               cnt_in    = '0;
               pend_in   = KIND_NONE;
               match_in  = '1;
               evt.start = 1'b1;
            end
         end else if (len_ff >= MAX_LEN) begin
            // drop the overlong frame silently
            phase_in = PH_WAIT;
         end else begin
            len_in = len_ff + LEN_W'(1);
            unique case (phase_ff)
               PH_BODY: begin
                  if (rx_byte == CH_STAR) begin
                     do_end   = 1'b1;
                     phase_in = PH_HEX_HI;
                  end else begin
                     xor_in = xor_ff ^ rx_byte;
                     if (rx_byte == CH_COMMA) do_end = 1'b1;
                     else do_char = 1'b1;
                  end
               end
               PH_HEX_HI: begin
                  hi_in    = hex[4] ? 4'd0 : hex[3:0];
                  bad_in   = hex[4];
                  phase_in = PH_HEX_LO;
               end
               PH_HEX_LO: begin
                  evt.finish = 1'b1;
                  phase_in   = PH_WAIT;
               end
               default: ;
            endcase
         end
      end

      if (do_char) begin
         if (idx_ff == FLD_TYPE) begin
            for (int i = 0; i < 3; i++) begin
               if (cnt_ff >= LEN_W'(5) || kind_char(2'(i), cnt_ff[2:0]) != rx_byte)
                  match_in[i] = 1'b0;
            end
         end else if (pend_ff == KIND_RMC) begin
            evt.chr = 1'b1;
         end
         if (cnt_ff != '1) cnt_in = cnt_ff + LEN_W'(1);
      end

      if (do_end) begin
         if (idx_ff == FLD_TYPE) begin
            pend_in = KIND_NONE;
            if (cnt_ff == LEN_W'(5)) begin
               if (match_ff[0])      pend_in = KIND_RMC;
               else if (match_ff[1]) pend_in = KIND_GGA;
               else if (match_ff[2]) pend_in = KIND_GSA;
            end
         end else if (pend_ff == KIND_RMC) begin
            evt.fend = 1'b1;
         end
         if (idx_ff != '1) idx_in = idx_ff + 5'd1;
         cnt_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_WAIT;
         len_ff   <= '0;
         xor_ff   <= '0;
         hi_ff    <= '0;
         bad_ff   <= 1'b0;
         idx_ff   <= '0;
         cnt_ff   <= '0;
         pend_ff  <= KIND_NONE;
         match_ff <= '1;
      end else begin
         phase_ff <= phase_in;
         len_ff   <= len_in;
         xor_ff   <= xor_in;
         hi_ff    <= hi_in;
         bad_ff   <= bad_in;
         idx_ff   <= idx_in;
         cnt_ff   <= cnt_in;
         pend_ff  <= pend_in;
         match_ff <= match_in;
      end
   end

endmodule

`default_nettype wire

[sv/nrmc_capture.sv]
`default_nettype none

module nrmc_capture (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire nrmc_pkg::nrmc_evt_type evt,
   output nrmc_pkg::nrmc_rsp_type      rsp
);
   import nrmc_pkg::*;

   typedef struct packed {
      logic tm;
      logic dt;
      logic fix;
      logic north;
      logic east;
      logic lat;
      logic lon;
      logic spd;
      logic crs;
   } seen_type;

   // shadow copies, filled while the frame runs
   logic [NUM_W-1:0] sh_time_ff, sh_time_in;
   logic [NUM_W-1:0] sh_date_ff, sh_date_in;
   logic             sh_fix_ff, sh_fix_in;
   logic             sh_north_ff, sh_north_in;
   logic             sh_east_ff, sh_east_in;
   logic [POS_W-1:0] sh_lat_ff, sh_lat_in;
   logic [POS_W-1:0] sh_lon_ff, sh_lon_in;
   logic [MOT_W-1:0] sh_spd_ff, sh_spd_in;
   logic [MOT_W-1:0] sh_crs_ff, sh_crs_in;
   logic             run_ff, run_in;
   seen_type         seen_ff, seen_in;

   // committed values
   logic [1:0]       kind_ff, kind_in;
   logic [NUM_W-1:0] time_ff, time_in;
   logic [NUM_W-1:0] date_ff, date_in;
   logic             fix_ff, fix_in;
   logic             north_ff, north_in;
   logic             east_ff, east_in;
   logic [POS_W-1:0] lat_ff, lat_in;
   logic [POS_W-1:0] lon_ff, lon_in;
   logic [MOT_W-1:0] spd_ff, spd_in;
   logic [MOT_W-1:0] crs_ff, crs_in;
   logic [15:0]      frames_ff, frames_in;

   logic             first;
   logic             dig;
   logic             run_now;
   logic [NUM_W-1:0] num_cur;
   logic [NUM_W+3:0] acc;
   logic [NUM_W-1:0] num_next;

   assign first   = (evt.count == '0);
   assign dig     = is_digit(evt.data);
   assign run_now = first ? dig : run_ff;
   assign num_cur = first ? '0 : ((evt.index == FLD_TIME) ? sh_time_ff : sh_date_ff);
   assign acc     = (NUM_W+4)'({num_cur, 3'b000}) + (NUM_W+4)'({num_cur, 1'b0})
                    + (NUM_W+4)'(evt.data[3:0]);
   assign num_next = (acc > (NUM_W+4)'(NUM_MAX)) ? NUM_MAX : acc[NUM_W-1:0];

   always_comb begin
      sh_time_in  = sh_time_ff;
      sh_date_in  = sh_date_ff;
      sh_fix_in   = sh_fix_ff;
      sh_north_in = sh_north_ff;
      sh_east_in  = sh_east_ff;
      sh_lat_in   = sh_lat_ff;
      sh_lon_in   = sh_lon_ff;
      sh_spd_in   = sh_spd_ff;
      sh_crs_in   = sh_crs_ff;
      run_in      = run_ff;
      seen_in     = seen_ff;
      kind_in     = kind_ff;
      time_in     = time_ff;
      date_in     = date_ff;
      fix_in      = fix_ff;
      north_in    = north_ff;
      east_in     = east_ff;
      lat_in      = lat_ff;
      lon_in      = lon_ff;
      spd_in      = spd_ff;
      crs_in      = crs_ff;
      frames_in   = frames_ff;

      if (evt.start) begin
         sh_time_in  = '0;
         sh_date_in  = '0;
         sh_fix_in   = 1'b0;
         sh_north_in = 1'b0;
         sh_east_in  = 1'b0;
         sh_lat_in   = '1;
         sh_lon_in   = '1;
         sh_spd_in   = '1;
         sh_crs_in   = '1;
         seen_in     = '0;
      end

      if (evt.chr) begin
         unique case (evt.index) inside
            FLD_TIME, FLD_DATE: begin
               if (first) begin
                  run_in = dig;
                  if (evt.index == FLD_TIME) seen_in.tm = dig;
                  else seen_in.dt = dig;
               end
               if (run_now && !dig) begin
                  run_in = 1'b0;
               end else if (run_now) begin
                  if (evt.index == FLD_TIME) sh_time_in = num_next;
                  else sh_date_in = num_next;
               end
            end
            FLD_STATUS: if (first) sh_fix_in = (evt.data == CH_A_UP);
            FLD_NS:     if (first) sh_north_in = (evt.data == CH_N_UP);
            FLD_EW:     if (first) sh_east_in = (evt.data == CH_E_UP);
            FLD_LAT:    sh_lat_in = put_pos(sh_lat_ff, evt.count, evt.data);
            FLD_LON:    sh_lon_in = put_pos(sh_lon_ff, evt.count, evt.data);
            FLD_SPEED:  sh_spd_in = put_mot(sh_spd_ff, evt.count, evt.data);
            FLD_COURSE: sh_crs_in = put_mot(sh_crs_ff, evt.count, evt.data);
            default: ;
         endcase
      end

      if (evt.fend) begin
         unique case (evt.index)
            FLD_STATUS: seen_in.fix   = 1'b1;
            FLD_LAT:    seen_in.lat   = 1'b1;
            FLD_NS:     seen_in.north = 1'b1;
            FLD_LON:    seen_in.lon   = 1'b1;
            FLD_EW:     seen_in.east  = 1'b1;
            FLD_SPEED:  seen_in.spd   = 1'b1;
            FLD_COURSE: seen_in.crs   = 1'b1;
            default: ;
         endcase
      end

      if (evt.finish) begin
         frames_in = frames_ff + 16'd1;
         if (evt.ok) begin
            kind_in = evt.kind;
            if (seen_ff.tm)    time_in  = sh_time_ff;
            if (seen_ff.dt)    date_in  = sh_date_ff;
            if (seen_ff.fix)   fix_in   = sh_fix_ff;
            if (seen_ff.north) north_in = sh_north_ff;
            if (seen_ff.east)  east_in  = sh_east_ff;
            if (seen_ff.lat)   lat_in   = sh_lat_ff;
            if (seen_ff.lon)   lon_in   = sh_lon_ff;
            if (seen_ff.spd)   spd_in   = sh_spd_ff;
            if (seen_ff.crs)   crs_in   = sh_crs_ff;
         end
      end
   end

   always_comb begin
      rsp.sentence_kind  = kind_in;
      rsp.checksum_ok    = evt.ok;
      rsp.utc_time       = time_in;
      rsp.fix_valid      = fix_in;
      rsp.is_north       = north_in;
      rsp.is_east        = east_in;
      rsp.latitude_text  = lat_in;
      rsp.longitude_text = lon_in;
      rsp.speed_text     = spd_in;
      rsp.course_text    = crs_in;
      rsp.date_value     = date_in;
      rsp.frame_count    = frames_in;
   end

   always_ff @(posedge clock) begin
      sh_time_ff  <= sh_time_in;
      sh_date_ff  <= sh_date_in;
      sh_fix_ff   <= sh_fix_in;
      sh_north_ff <= sh_north_in;
      sh_east_ff  <= sh_east_in;
      sh_lat_ff   <= sh_lat_in;
      sh_lon_ff   <= sh_lon_in;
      sh_spd_ff   <= sh_spd_in;
      sh_crs_ff   <= sh_crs_in;
      run_ff      <= run_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff   <= '0;
         kind_ff   <= KIND_NONE;
         time_ff   <= '0;
         date_ff   <= '0;
         fix_ff    <= 1'b0;
         north_ff  <= 1'b1;
         east_ff   <= 1'b0;
         lat_ff    <= '1;
         lon_ff    <= '1;
         spd_ff    <= '1;
         crs_ff    <= '1;
         frames_ff <= '0;
      end else begin
         seen_ff   <= seen_in;
         kind_ff   <= kind_in;
         time_ff   <= time_in;
         date_ff   <= date_in;
         fix_ff    <= fix_in;
         north_ff  <= north_in;
         east_ff   <= east_in;
         lat_ff    <= lat_in;
         lon_ff    <= lon_in;
         spd_ff    <= spd_in;
         crs_ff    <= crs_in;
         frames_ff <= frames_in;
      end
   end

endmodule

`default_nettype wire

[sv/nmea_rmc_sentence_parser_top.sv]
// NMEA sentence parser with RMC field capture.
//
// req_ carries one received character per word. Characters before a '$' are
// skipped; a frame runs from '$' to '*' and two hex checksum digits. rsp_
// carries one snapshot word per completed frame: the committed RMC fields,
// the last accepted sentence kind, whether this frame is a known kind with a
// good checksum and a frame count. Frames over 80 bytes are dropped silently.
//
// Throughput is one character per cycle unless a final checksum digit meets
// a stalled rsp_. A character is held in an input register, then runs
// through the per-byte update, and the snapshot of a finished frame lands in
// the result register, which drives rsp_tvalid.
// While rsp_ stalls, characters that end no frame keep flowing; only a final
// checksum digit waits in the input register, and req_tready then stays low
// until the pending word is taken.
// Reset clears framing state, the frame count and the committed fields
// (north set, texts all pad) and empties both registers.
`default_nettype none

module nmea_rmc_sentence_parser_top (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [7:0]   req_tdata,   // [7:0] rx_byte
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // [1:0] sentence_kind, [2] checksum_ok, [22:3] utc_time, [23] fix_valid,
   // [24] is_north, [25] is_east, [69:26] latitude_text,
   // [113:70] longitude_text, [133:114] speed_text, [153:134] course_text,
   // [173:154] date_value, [189:174] frame_count, [191:190] zero
   output logic [191:0]      rsp_tdata
);
   import nrmc_pkg::*;

   logic         s1_valid_ff, s1_valid_in;
   logic [7:0]   s1_data_ff, s1_data_in;
   logic         rsp_valid_ff, rsp_valid_in;
   nrmc_rsp_type rsp_data_ff, rsp_data_in;

   logic         due;
   logic         out_free;
   logic         fire;
   nrmc_evt_type evt;
   nrmc_rsp_type snap;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign fire       = s1_valid_ff && (out_free || !due);
   assign req_tready = !s1_valid_ff || fire;

   nrmc_framer u_framer (
      .clock      (clock),
      .reset      (reset),
      .step       (fire),
      .rx_byte    (s1_data_ff),
      .result_due (due),
      .evt        (evt)
   );

   nrmc_capture u_capture (
      .clock (clock),
      .reset (reset),
      .evt   (evt),
      .rsp   (snap)
   );

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_data_in   = s1_data_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (req_tvalid && req_tready) begin
         s1_valid_in = 1'b1;
         s1_data_in  = req_tdata;
      end else if (fire) begin
         s1_valid_in = 1'b0;
      end
      if (fire && due) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = snap;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      s1_data_ff  <= s1_data_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00,
                        rsp_data_ff.frame_count,
                        rsp_data_ff.date_value,
                        rsp_data_ff.course_text,
                        rsp_data_ff.speed_text,
                        rsp_data_ff.longitude_text,
                        rsp_data_ff.latitude_text,
                        rsp_data_ff.is_east,
                        rsp_data_ff.is_north,
                        rsp_data_ff.fix_valid,
                        rsp_data_ff.utc_time,
                        rsp_data_ff.checksum_ok,
                        rsp_data_ff.sentence_kind};

`ifndef SYNTHESIS
   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !fire |=> s1_valid_ff && $stable(s1_data_ff))
      else $error("held character lost from input register");

   a_result_loads: assert property (@(posedge clock) disable iff (reset)
      fire && due |=> rsp_valid_ff)
      else $error("finished frame gave no result word");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |-> !(fire && due))
      else $error("pending result word overwritten");
`endif

endmodule

`default_nettype wire
